[sv/ptst_pkg.sv]
package ptst_pkg;

    // Table size default and field widths.
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_W           = 16;
    localparam int PROB_W          = 20;
    localparam int ADJ_W           = 21;
    localparam int CNT32_W         = 32;
    localparam int S_TDATA_W       = 64;
    localparam int M_TDATA_W       = 72;

    // Probability limits in millionths.
    localparam logic [PROB_W-1:0] PROB_FULL    = 20'd1000000;
    localparam logic [PROB_W-1:0] PROB_DEFAULT = 20'd500000;

    // Commands.
    localparam logic [1:0] CMD_ENTER    = 2'd0;
    localparam logic [1:0] CMD_EVALUATE = 2'd1;
    localparam logic [1:0] CMD_ADJUST   = 2'd2;
    localparam logic [1:0] CMD_NOP      = 2'd3;

    // Thread states.
    localparam logic [1:0] ST_SLEEPING  = 2'd0;
    localparam logic [1:0] ST_UNDECIDED = 2'd1;
    localparam logic [1:0] ST_RUNNING   = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // One table entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [1:0]         state;
        logic [PROB_W-1:0]  prob;
        logic [CNT32_W-1:0] transitions;
        logic [CNT32_W-1:0] resolutions;
    } entry_t;

endpackage

[sv/ptst_alu.sv]
module ptst_alu
    import ptst_pkg::*;
(
    input  logic [1:0]        op,
    input  entry_t            entry_in,
    input  logic [ADJ_W-1:0]  adjustment,
    input  logic [PROB_W-1:0] random_value,
    output entry_t            entry_out
);

    logic [PROB_W+2:0]  sum;
    logic               sum_neg;
    logic               sum_over;
    logic [PROB_W-1:0]  prob_sat;
    logic [CNT32_W-1:0] trans_inc;
    logic [CNT32_W-1:0] resol_inc;
    logic               draw_runs;

    // Saturating probability update: the sum is evaluated in 23 bits.
    always_comb begin
        sum       = {3'b000, entry_in.prob} + {{2{adjustment[ADJ_W-1]}}, adjustment};
        sum_neg   = sum[PROB_W+2];
        sum_over  = !sum_neg && (sum[PROB_W+1:0] > {2'b00, PROB_FULL});
        prob_sat  = sum_neg ? '0 : (sum_over ? PROB_FULL : sum[PROB_W-1:0]);
        trans_inc = entry_in.transitions + 32'd1;
        resol_inc = entry_in.resolutions + 32'd1;
        draw_runs = random_value < entry_in.prob;
    end

    // Entry update for evaluate and adjust; other operations pass the entry.
    always_comb begin
        entry_out = entry_in;
        unique case (op)
            CMD_EVALUATE: begin
                if (entry_in.state == ST_UNDECIDED) begin
                    entry_out.state       = draw_runs ? ST_RUNNING : ST_SLEEPING;
                    entry_out.transitions = trans_inc;
                    entry_out.resolutions = resol_inc;
                end
            end
            CMD_ADJUST: begin
                entry_out.prob        = prob_sat;
                entry_out.state       = ST_UNDECIDED;
                entry_out.transitions = trans_inc;
            end
            default: begin
                entry_out = entry_in;
            end
        endcase
    end

endmodule

[sv/probabilistic_thread_state_table_core.sv]
// Enter, the unused command and a lookup in an empty table go from acceptance straight to the
// result stage. Evaluate and adjust scan from the newest entry, one entry per cycle through the
// registered read port, then update a hit entry in the execute state before the result stage.
// The next transaction is taken only after the result is loaded into the output register, so a
// stalled result delays it.
// Reset (aresetn low, synchronous) empties the table and sets the initial probability to 500000.
module probabilistic_thread_state_table_core
    import ptst_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // cfg_wdata: initial_probability
    input  logic                 cfg_we,
    input  logic [PROB_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata from bit 0: cmd[1:0], thread_key[17:2], adjustment[38:18],
    // random_value[58:39], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata from bit 0: status[1:0], thread_state[3:2], transition_count[35:4],
    // resolution_count[67:36], zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [PROB_W-1:0]   init_prob_reg;
    logic [CNT_W-1:0]    fill_level_reg, fill_level_next;

    // Latched request.
    logic [1:0]          cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [ADJ_W-1:0]    adj_reg;
    logic [PROB_W-1:0]   rnd_reg;

    // Scan pointer and registered read port.
    logic [IDX_W-1:0]    scan_addr_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_last_reg;
    logic                rd_vld_reg;
    entry_t              rd_data_reg;
    logic                rd_en;
    logic                key_hit;

    // Result staging and output register.
    logic [1:0]          res_status_reg, res_status_next;
    logic [1:0]          res_state_reg, res_state_next;
    logic [CNT32_W-1:0]  res_trans_reg, res_trans_next;
    logic [CNT32_W-1:0]  res_resol_reg, res_resol_next;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                out_free;

    // Table memory.
    entry_t              table_mem [TABLE_DEPTH];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    entry_t              mem_wdata;
    entry_t              new_entry;
    entry_t              alu_out;

    // Input fields.
    logic [1:0]          s_cmd;
    logic [KEY_W-1:0]    s_key;
    logic [ADJ_W-1:0]    s_adj;
    logic [PROB_W-1:0]   s_rnd;
    logic                s_accept;
    logic                table_full;

    assign s_cmd    = s_tdata[1:0];
    assign s_key    = s_tdata[17:2];
    assign s_adj    = s_tdata[38:18];
    assign s_rnd    = s_tdata[58:39];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign table_full = (fill_level_reg >= CNT_W'(TABLE_DEPTH));
    assign key_hit    = rd_vld_reg && (rd_data_reg.key == key_reg);
    assign rd_en      = (state_reg == S_SCAN) && !(rd_vld_reg && (key_hit || rd_last_reg));

    // Fresh entry for enter, probability saturated to full.
    always_comb begin
        new_entry.key         = s_key;
        new_entry.state       = ST_UNDECIDED;
        new_entry.prob        = (init_prob_reg > PROB_FULL) ? PROB_FULL : init_prob_reg;
        new_entry.transitions = 32'd1;
        new_entry.resolutions = '0;
    end

    ptst_alu u_alu (
        .op           (cmd_reg),
        .entry_in     (rd_data_reg),
        .adjustment   (adj_reg),
        .random_value (rnd_reg),
        .entry_out    (alu_out)
    );

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        fill_level_next = fill_level_reg;
        res_status_next = res_status_reg;
        res_state_next  = res_state_reg;
        res_trans_next  = res_trans_reg;
        res_resol_next  = res_resol_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_idx_reg;
        mem_wdata       = alu_out;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next      = S_RESP;
                    res_status_next = STATUS_OK;
                    res_state_next  = ST_SLEEPING;
                    res_trans_next  = '0;
                    res_resol_next  = '0;
                    case (s_cmd)
                        CMD_ENTER: begin
                            if (table_full) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                mem_we          = 1'b1;
                                mem_waddr       = fill_level_reg[IDX_W-1:0];
                                mem_wdata       = new_entry;
                                fill_level_next = fill_level_reg + 1'b1;
                                res_state_next  = new_entry.state;
                                res_trans_next  = new_entry.transitions;
                                res_resol_next  = new_entry.resolutions;
                            end
                        end
                        CMD_NOP: begin
                            res_status_next = STATUS_OK;
                        end
                        default: begin
                            if (fill_level_reg == '0) begin
                                res_status_next = STATUS_NOT_FOUND;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (key_hit) begin
                    state_next = S_EXEC;
                end else if (rd_vld_reg && rd_last_reg) begin
                    state_next      = S_RESP;
                    res_status_next = STATUS_NOT_FOUND;
                end
            end
            S_EXEC: begin
                mem_we          = 1'b1;
                state_next      = S_RESP;
                res_status_next = STATUS_OK;
                res_state_next  = alu_out.state;
                res_trans_next  = alu_out.transitions;
                res_resol_next  = alu_out.resolutions;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fill_level_reg <= '0;
            init_prob_reg  <= PROB_DEFAULT;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_level_reg <= fill_level_next;
            rd_vld_reg     <= rd_en;
            if (cfg_we) begin
                init_prob_reg <= cfg_wdata;
            end
            if (state_reg == S_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request, scan pointer and result payload.
    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_state_reg  <= res_state_next;
        res_trans_reg  <= res_trans_next;
        res_resol_reg  <= res_resol_next;
        if (s_accept) begin
            cmd_reg       <= s_cmd;
            key_reg       <= s_key;
            adj_reg       <= s_adj;
            rnd_reg       <= s_rnd;
            scan_addr_reg <= IDX_W'(fill_level_reg - 1'b1);
        end else if (rd_en) begin
            scan_addr_reg <= scan_addr_reg - 1'b1;
        end
        if (rd_en) begin
            rd_idx_reg  <= scan_addr_reg;
            rd_last_reg <= (scan_addr_reg == '0);
        end
        if (state_reg == S_RESP && out_free) begin
            m_tdata_reg <= {4'b0000, res_resol_reg, res_trans_reg, res_state_reg, res_status_reg};
        end
    end

    // Table memory write port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Table memory read port, data registered.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem[scan_addr_reg];
        end
    end

endmodule

[sv/ptst_checker.sv]
module ptst_checker
    import ptst_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    // Only defined status codes are reported.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == STATUS_OK || m_tdata[1:0] == STATUS_NOT_FOUND ||
                      m_tdata[1:0] == STATUS_FULL))
        else $error("undefined status code");

    // A failed operation reports no entry.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != STATUS_OK |-> m_tdata[67:2] == '0)
        else $error("failed operation reports entry fields");

    // The input side is idle at the cycle right after reset is released.
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

endmodule

bind probabilistic_thread_state_table_core ptst_checker u_ptst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
